FILE: rtl/irnpd_pkg.sv
package irnpd_pkg;

	// Width of a decoded duration
	localparam int DUR_W = 24;
	// Result stream data bus, rounded up to whole bytes
	localparam int M_DATA_W = ((DUR_W + 7) / 8) * 8;
	localparam int ELAPSED_W = 24;
	// Wide enough for the gap sum and for the duration itself
	localparam int SUM_W = (DUR_W > ELAPSED_W + 1) ? DUR_W : ELAPSED_W + 1;

	localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;
	localparam logic [3:0] NIB_ESC = 4'hF;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
	localparam logic [SUM_W-1:0] GAP_BASE_US = SUM_W'(255 * 256);
	localparam logic [SUM_W-1:0] DUR_MAX_WIDE = SUM_W'((64'd1 << DUR_W) - 64'd1);

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Up to three results caused by one byte
	typedef struct packed {
		logic [1:0]                cnt;
		logic [2:0]                pulse;
		logic [2:0][DUR_W-1:0]     dur;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   empty;
		entry_t entry;
	} head_t;

	// Nibble or full byte in 256 us units, plus half a unit
	function automatic logic [DUR_W-1:0] unit_dur(input logic [7:0] units);
		return DUR_W'({units, 8'h80});
	endfunction

endpackage

FILE: rtl/irnpd_front.sv
module irnpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic              accept,
	output irnpd_pkg::push_t  push
);

	logic                              full_pending_q;
	logic                              full_is_pulse_q;
	logic                              gap_armed_q;
	logic [irnpd_pkg::ELAPSED_W-1:0]   elapsed_q;

	logic [3:0]                        hi;
	logic [3:0]                        lo;
	logic                              is_timeout;
	logic                              is_space_esc;
	logic                              is_pulse_esc;
	logic                              is_byte;
	logic [irnpd_pkg::SUM_W-1:0]       gap_sum;
	logic [irnpd_pkg::DUR_W-1:0]       gap_dur;
	irnpd_pkg::entry_t                 ent;
	logic [1:0]                        n;

	assign hi           = rx_byte[7:4];
	assign lo           = rx_byte[3:0];
	assign is_byte      = valid && accept && (kind == irnpd_pkg::KIND_BYTE);
	assign is_timeout   = (rx_byte == irnpd_pkg::TIMEOUT_BYTE);
	assign is_space_esc = !is_timeout && (lo == irnpd_pkg::NIB_ESC);
	assign is_pulse_esc = !is_timeout && !is_space_esc && (hi == irnpd_pkg::NIB_ESC);

	assign gap_sum = irnpd_pkg::SUM_W'(elapsed_q) + irnpd_pkg::GAP_BASE_US;
	assign gap_dur = (gap_sum > irnpd_pkg::DUR_MAX_WIDE) ?
		irnpd_pkg::DUR_W'(irnpd_pkg::DUR_MAX_WIDE) : irnpd_pkg::DUR_W'(gap_sum);

	// Collect the results of this byte in order
	always_comb begin
		ent   = '0;
		n     = 2'd0;
		if (is_timeout || is_pulse_esc) begin
			n = 2'd0;
		end else if (is_space_esc) begin
			if (hi != 4'd0) begin
				ent.dur[0]   = irnpd_pkg::unit_dur({4'd0, hi});
				ent.pulse[0] = 1'b1;
				n            = 2'd1;
			end
		end else begin
			if (gap_armed_q) begin
				ent.dur[n]   = gap_dur;
				ent.pulse[n] = 1'b0;
				n            = n + 2'd1;
			end
			if (full_pending_q) begin
				ent.dur[n]   = irnpd_pkg::unit_dur(rx_byte);
				ent.pulse[n] = full_is_pulse_q;
				n            = n + 2'd1;
			end else begin
				if (hi != 4'd0) begin
					ent.dur[n]   = irnpd_pkg::unit_dur({4'd0, hi});
					ent.pulse[n] = 1'b1;
					n            = n + 2'd1;
				end
				ent.dur[n]   = irnpd_pkg::unit_dur({4'd0, lo});
				ent.pulse[n] = 1'b0;
				n            = n + 2'd1;
			end
		end
		ent.cnt = n;
	end

	assign push.valid = is_byte && (n != 2'd0);
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_pending_q  <= 1'b0;
			full_is_pulse_q <= 1'b1;
			gap_armed_q     <= 1'b1;
			elapsed_q       <= '0;
		end else if (valid && accept) begin
			if (kind == irnpd_pkg::KIND_TICK) begin
				if (elapsed_q != irnpd_pkg::ELAPSED_MAX) begin
					elapsed_q <= elapsed_q + irnpd_pkg::ELAPSED_W'(1);
				end
			end else if (is_timeout) begin
				gap_armed_q     <= 1'b1;
				full_pending_q  <= 1'b0;
				full_is_pulse_q <= 1'b1;
				elapsed_q       <= '0;
			end else if (is_space_esc) begin
				full_pending_q  <= 1'b1;
				full_is_pulse_q <= 1'b0;
			end else if (is_pulse_esc) begin
				full_pending_q  <= 1'b1;
				full_is_pulse_q <= 1'b1;
			end else begin
				if (gap_armed_q) begin
					gap_armed_q <= 1'b0;
					elapsed_q   <= '0;
				end
				full_pending_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/irnpd_queue.sv
module irnpd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  irnpd_pkg::push_t  push,
	input  logic              pop,
	output logic              full,
	output irnpd_pkg::head_t  head
);

	irnpd_pkg::entry_t  slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == 2'd2);
	assign head.empty = (count_q == 2'd0);
	assign head.entry = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/irnpd_back.sv
module irnpd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  irnpd_pkg::head_t            head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [irnpd_pkg::DUR_W-1:0] out_dur,
	output logic                        out_pulse,
	output logic                        out_last
);

	logic [1:0]  idx_q;
	logic        valid_q;
	logic        load;
	logic        at_last;

	assign load    = !head.empty && (!valid_q || out_ready);
	assign at_last = (idx_q == head.entry.cnt - 2'd1);
	assign pop     = load && at_last;

	assign out_valid = valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_dur   <= head.entry.dur[idx_q];
			out_pulse <= head.entry.pulse[idx_q];
			out_last  <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/ir_nibble_pulse_space_decoder.sv
// Infrared nibble pulse/space decoder.
// Input channel (s_*): one request is either a received byte (s_tuser = 0,
// byte in s_tdata) or a one-microsecond tick (s_tuser = 1, s_tdata ignored).
// Output channel (m_*): one request per decoded duration; m_tdata holds the
// duration in microseconds, m_tuser is 1 for a pulse and 0 for a space or gap,
// m_tlast marks the final duration caused by one input byte.
// The first duration of a byte is registered in the queue and then in the
// output register; following durations of the same byte come one per cycle
// while m_tready is high. Throughput: one output request per cycle while
// m_tready is high, and a byte yields up to three durations; ticks, timeouts,
// pulse escapes and space escapes with a zero high nibble yield nothing, and
// every request is taken in the cycle it is offered while the queue has room.
// The front stage decodes each byte and the back stage serializes results
// through a two-entry queue; s_tready drops only while that queue is full.
// Reset: the queue and the output register empty, a gap is armed, no full
// value is pending and the elapsed counter is cleared.
// Output stall: the current output request holds until m_tready; the front
// keeps taking requests until the queue fills.
module ir_nibble_pulse_space_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
	input  logic                           s_tuser,   // [0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [irnpd_pkg::M_DATA_W-1:0] m_tdata,   // [23:0] duration_us
	output logic                           m_tuser,   // [0] is_pulse
	output logic                           m_tlast
);

	irnpd_pkg::push_t             push;
	irnpd_pkg::head_t             head;
	logic                         q_full;
	logic                         pop;
	logic [irnpd_pkg::DUR_W-1:0]  dur;

	// Hold off new requests only while the queue is full
	assign s_tready = !q_full;

	irnpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (s_tvalid),
		.kind    (s_tuser),
		.rx_byte (s_tdata),
		.accept  (s_tready),
		.push    (push)
	);

	irnpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	irnpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_dur   (dur),
		.out_pulse (m_tuser),
		.out_last  (m_tlast)
	);

	// Pad the duration with zeros up to a whole byte
	assign m_tdata = irnpd_pkg::M_DATA_W'(dur);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int CLK_PERIOD = 20;
	// Generous cap: the slowest correct run stays well below a tenth of this
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 210;
	localparam int MAX_REPORTS = 10;
	localparam int GAP_OFFSET_US = 255 * 256;
	localparam logic [32:0] DUR_CEIL = (33'd1 << irnpd_pkg::DUR_W) - 33'd1;

	// One request toward the decoder: a received byte or a microsecond tick
	typedef struct packed {
		logic       kind;
		logic [7:0] rx;
	} rx_req_t;

	// One decoded duration as it should leave the decoder
	typedef struct packed {
		logic [irnpd_pkg::DUR_W-1:0] dur;
		logic                        pulse;
		logic                        last;
	} dur_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata = 8'h00;   // [7:0] rx_byte
	logic                           s_tuser = 1'b0;    // [0] kind
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [irnpd_pkg::M_DATA_W-1:0] m_tdata;           // [23:0] duration_us
	logic                           m_tuser;           // [0] is_pulse
	logic                           m_tlast;

	// Stimulus waiting to be offered, and durations waiting to come out
	rx_req_t  rx_req_q[$];
	dur_res_t dur_exp_q[$];

	// Decoder state as the testbench tracks it
	logic                            full_pending;
	logic                            full_is_pulse;
	logic                            gap_armed;
	logic [irnpd_pkg::ELAPSED_W-1:0] elapsed_us;

	// Idle control for both sides
	logic       quiet = 1'b0;
	logic       hold_off = 1'b0;
	logic [3:0] src_idle, snk_idle;
	logic [6:0] src_calm, snk_calm;

	int errors = 0;
	int bytes_in = 0, ticks_in = 0, results_seen = 0;
	int gaps_seen = 0, pulses_seen = 0, spaces_seen = 0;
	int stalled_offers = 0;

	ir_nibble_pulse_space_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Nibble or full byte counted in 256 us units, centered in its unit
	function automatic logic [irnpd_pkg::DUR_W-1:0] half_unit_us(input logic [7:0] units);
		return irnpd_pkg::DUR_W'(units) * irnpd_pkg::DUR_W'(256) + irnpd_pkg::DUR_W'(128);
	endfunction

	// Advance the tracked state by one accepted request and queue the
	// durations it must produce, the final one flagged as last.
	task automatic predict_durations(input logic kind, input logic [7:0] rx);
		dur_res_t    res [3];
		int          n;
		logic [3:0]  hi, lo;
		logic [32:0] gap_sum;
		n = 0;
		hi = rx[7:4];
		lo = rx[3:0];
		if (kind == irnpd_pkg::KIND_TICK) begin
			// elapsed time saturates instead of wrapping
			if (elapsed_us != irnpd_pkg::ELAPSED_MAX)
				elapsed_us = elapsed_us + 1'b1;
			ticks_in++;
		end else begin
			bytes_in++;
			if (rx == irnpd_pkg::TIMEOUT_BYTE) begin
				gap_armed = 1'b1;
				full_pending = 1'b0;
				full_is_pulse = 1'b1;
				elapsed_us = '0;
			end else if (lo == irnpd_pkg::NIB_ESC) begin
				// space escape: the high nibble may still carry a pulse
				full_pending = 1'b1;
				full_is_pulse = 1'b0;
				if (hi != 4'd0) begin
					res[n] = '{dur: half_unit_us({4'd0, hi}), pulse: 1'b1, last: 1'b0};
					n++;
				end
			end else if (hi == irnpd_pkg::NIB_ESC) begin
				full_pending = 1'b1;
				full_is_pulse = 1'b1;
			end else begin
				if (gap_armed) begin
					gap_sum = 33'(elapsed_us) + 33'(GAP_OFFSET_US);
					if (gap_sum > DUR_CEIL)
						gap_sum = DUR_CEIL;
					res[n] = '{dur: irnpd_pkg::DUR_W'(gap_sum), pulse: 1'b0, last: 1'b0};
					n++;
					gaps_seen++;
					gap_armed = 1'b0;
					elapsed_us = '0;
				end
				if (full_pending) begin
					res[n] = '{dur: half_unit_us(rx), pulse: full_is_pulse, last: 1'b0};
					n++;
					full_pending = 1'b0;
				end else begin
					if (hi != 4'd0) begin
						res[n] = '{dur: half_unit_us({4'd0, hi}), pulse: 1'b1, last: 1'b0};
						n++;
					end
					res[n] = '{dur: half_unit_us({4'd0, lo}), pulse: 1'b0, last: 1'b0};
					n++;
				end
			end
			if (n > 0)
				res[n-1].last = 1'b1;
			for (int i = 0; i < n; i++)
				dur_exp_q.push_back(res[i]);
		end
	endtask

	task automatic note_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("tb_top: result %0d: %s expected %0d, got %0d at %0t",
				results_seen, what, want, got, $realtime);
	endtask

	task automatic push_byte(input logic [7:0] rx);
		rx_req_q.push_back('{kind: irnpd_pkg::KIND_BYTE, rx: rx});
	endtask

	// Ticks carry random byte content, which the decoder must ignore
	task automatic push_ticks(input int count);
		for (int i = 0; i < count; i++)
			rx_req_q.push_back('{kind: irnpd_pkg::KIND_TICK, rx: 8'($urandom_range(0, 255))});
	endtask

	// Random data byte: neither nibble may be the escape value
	function automatic logic [7:0] rand_data_byte();
		return {4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))};
	endfunction

	// Driver: offer queued requests, holding each one until the decoder
	// takes it; insert idle bursts between requests.
	always @(posedge clk or negedge arst_n) begin : driver
		rx_req_t    req;
		logic       busy;
		logic [3:0] idle_n;
		logic [6:0] calm_n;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= 1'b0;
			src_idle <= '0;
			src_calm <= '0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_durations(s_tuser, s_tdata);
				busy = 1'b0;
			end else if (s_tvalid && hold_off) begin
				stalled_offers++;
			end
			idle_n = src_idle;
			calm_n = src_calm;
			if (calm_n != 0)
				calm_n--;
			if (!busy) begin
				if (idle_n != 0) begin
					idle_n--;
					s_tvalid <= 1'b0;
				end else if (!quiet && calm_n == 0 && $urandom_range(0, 5) == 0) begin
					// idle now, then load a random idle count
					idle_n = 4'($urandom_range(0, 9));
					if ($urandom_range(0, 2) == 0)
						calm_n = 7'($urandom_range(20, 80));
					s_tvalid <= 1'b0;
				end else if (rx_req_q.size() > 0) begin
					req = rx_req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= req.kind;
					s_tdata <= req.rx;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			src_idle <= idle_n;
			src_calm <= calm_n;
		end
	end

	// Monitor: check each duration against the oldest expectation and
	// drive m_tready with its own stalls.
	always @(posedge clk or negedge arst_n) begin : monitor
		dur_res_t   want;
		logic       rdy;
		logic [3:0] idle_n;
		logic [6:0] calm_n;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_idle <= '0;
			snk_calm <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (dur_exp_q.size() == 0) begin
					note_mismatch("unexpected duration, queue empty; duration", 0, m_tdata);
				end else begin
					want = dur_exp_q.pop_front();
					if (want.pulse)
						pulses_seen++;
					else
						spaces_seen++;
					if (m_tdata !== irnpd_pkg::M_DATA_W'(want.dur))
						note_mismatch("duration_us", want.dur, m_tdata);
					if (m_tuser !== want.pulse)
						note_mismatch("is_pulse", want.pulse, m_tuser);
					if (m_tlast !== want.last)
						note_mismatch("last", want.last, m_tlast);
				end
			end
			rdy = 1'b1;
			idle_n = snk_idle;
			calm_n = snk_calm;
			if (calm_n != 0)
				calm_n--;
			if (hold_off) begin
				rdy = 1'b0;
			end else if (idle_n != 0) begin
				idle_n--;
				rdy = 1'b0;
			end else if (!quiet && calm_n == 0 && $urandom_range(0, 5) == 0) begin
				idle_n = 4'($urandom_range(0, 9));
				if ($urandom_range(0, 2) == 0)
					calm_n = 7'($urandom_range(20, 80));
				rdy = 1'b0;
			end
			m_tready <= rdy;
			snk_idle <= idle_n;
			snk_calm <= calm_n;
		end
	end

	// Long receiver hold-off: the sender keeps offering, so the result
	// queue fills and the decoder must drop s_tready.
	initial begin
		wait (bytes_in >= 50);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("tb_top: timeout, %0d durations still expected", dur_exp_q.size());
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		int rnd_items;
		int pick;
		logic [3:0] nib;

		// State after reset: gap armed, nothing pending, elapsed cleared
		full_pending = 1'b0;
		full_is_pulse = 1'b1;
		gap_armed = 1'b1;
		elapsed_us = '0;

		// First data byte after reset: gap then a lone space (zero high nibble)
		push_ticks(5);
		push_byte(8'h00);
		// largest nibbles on either side
		push_byte(8'hE0);
		push_byte(8'h0E);
		push_byte(8'hEE);
		// space escape carrying a pulse, then a full space
		push_byte(8'hEF);
		push_byte(8'h12);
		// space escape with no pulse, then the largest full space
		push_byte(8'h0F);
		push_byte(8'hEE);
		// pulse escape, then the smallest full pulse
		push_byte(8'hF0);
		push_byte(8'h00);
		// pulse escape dropped by a timeout; gap holds the elapsed time
		push_byte(8'hFE);
		push_byte(8'hFF);
		push_ticks(20);
		push_byte(8'h77);
		// back-to-back timeouts, gap with no elapsed time
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h35);
		// pulse escape overridden by a space escape
		push_byte(8'hF3);
		push_byte(8'h4F);
		push_byte(8'h21);
		// two pulse escapes in a row
		push_byte(8'hF5);
		push_byte(8'hF5);
		push_byte(8'h01);
		// timeout while a full value is pending, then plain nibbles
		push_byte(8'h8F);
		push_byte(8'hFF);
		push_ticks(3);
		push_byte(8'hA5);

		// Random part: mostly well-formed traffic, some raw noise bytes
		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				push_byte(rand_data_byte());
				rnd_items += 1;
			end else if (pick < 60) begin
				nib = 4'($urandom_range(0, 14));
				if ($urandom_range(0, 1) == 0)
					push_byte({nib, irnpd_pkg::NIB_ESC});
				else
					push_byte({irnpd_pkg::NIB_ESC, nib});
				push_byte(rand_data_byte());
				rnd_items += 2;
			end else if (pick < 70) begin
				pick = $urandom_range(1, 8);
				push_byte(irnpd_pkg::TIMEOUT_BYTE);
				push_ticks(pick);
				rnd_items += 1 + pick;
			end else if (pick < 85) begin
				pick = $urandom_range(1, 5);
				push_ticks(pick);
				rnd_items += pick;
			end else begin
				push_byte(8'($urandom_range(0, 255)));
				rnd_items += 1;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drop all idling for the tail of the run
		wait (rx_req_q.size() < 30);
		@(posedge clk);
		quiet <= 1'b1;

		wait (rx_req_q.size() == 0 && s_tvalid == 1'b0);
		wait (dur_exp_q.size() == 0);
		repeat (20) @(posedge clk);

		if (dur_exp_q.size() != 0)
			errors++;
		$display("tb_top: %0d bytes and %0d ticks sent, %0d durations checked",
			bytes_in, ticks_in, results_seen);
		$display("tb_top: %0d gaps, %0d pulses, %0d spaces; %0d offers stalled in hold-off",
			gaps_seen, pulses_seen, spaces_seen, stalled_offers);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d mismatches", errors);
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
